// ===== design/gfi_pkg.sv =====
// ----------------------------------------------------------------------------
// GF(2^m) inverse package
// Shared widths, reset values, register indexes, controller types and the
// polynomial degree function used by the inverse datapath.
// ----------------------------------------------------------------------------
package gfi_pkg;

	localparam int OPERAND_W          = 8;
	localparam int MOD_W              = 9;
	localparam int DEGREE_W           = 4;
	localparam int POLY_W             = 9;
	localparam int PDEG_W             = 4;
	localparam int REG_IDX_W          = 1;
	localparam int MIN_DEGREE         = 2;
	localparam int DEFAULT_MAX_DEGREE = 8;

	localparam logic [MOD_W-1:0]     MODULUS_RESET = 9'd283;
	localparam logic [DEGREE_W-1:0]  DEGREE_RESET  = 4'd8;

	localparam logic [REG_IDX_W-1:0] REG_MODULUS = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_DEGREE  = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DONE
	} gfi_state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic finish;
	} gfi_cmd_t;

	typedef struct packed {
		logic v_low;
		logic u_zero;
		logic u_one;
	} gfi_status_t;

	// Index of the highest set coefficient; a zero polynomial reads as degree 0.
	function automatic logic [PDEG_W-1:0] poly_deg(input logic [POLY_W-1:0] p);
		logic [PDEG_W-1:0] d;
		d = '0;
		for (int i = 0; i < POLY_W; i++) begin
			if (p[i]) begin
				d = PDEG_W'(i);
			end
		end
		return d;
	endfunction

endpackage

// ===== design/gfi_ctrl.sv =====
// ----------------------------------------------------------------------------
// GF(2^m) inverse controller
// Sequences one transaction: load the operand, iterate reduction steps until
// the datapath reports a final condition, then strobe the result.
// ----------------------------------------------------------------------------
module gfi_ctrl
	import gfi_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  gfi_status_t status,
	output gfi_cmd_t    cmd,
	output logic        busy,
	output logic        done
);

	gfi_state_t state_q;
	gfi_state_t state_nx;
	logic       final_cond;

	assign final_cond = status.v_low | status.u_zero | status.u_one;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_nx = ST_RUN;
				end
			end
			ST_RUN: begin
				if (final_cond) begin
					state_nx = ST_DONE;
				end
			end
			ST_DONE: begin
				state_nx = ST_IDLE;
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		done = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			ST_RUN: begin
				cmd.finish = final_cond;
				cmd.step   = ~final_cond;
			end
			ST_DONE: begin
				done = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	a_load_runs: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == ST_RUN)
		else $error("Accepted transaction did not enter the run state.");

	a_finish_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> done)
		else $error("Finished transaction was not strobed out.");

	a_done_once: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done && !busy)
		else $error("Result strobe lasted more than one cycle.");

	a_done_after_run: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_RUN))
		else $error("Result strobe without a preceding run.");

endmodule

// ===== design/gfi_datapath.sv =====
// ----------------------------------------------------------------------------
// GF(2^m) inverse datapath
// Holds the remainder pair and the Bezout coefficient pair. Each step shifts
// the lower degree remainder to align it under the other and XORs it in, and
// applies the same shift and XOR to the coefficients.
// ----------------------------------------------------------------------------
module gfi_datapath
	import gfi_pkg::*;
#(
	parameter int MAX_DEGREE = DEFAULT_MAX_DEGREE
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  gfi_cmd_t              cmd,
	input  logic [OPERAND_W-1:0]  operand,
	input  logic [MOD_W-1:0]      modulus_poly,
	input  logic [DEGREE_W-1:0]   field_degree,
	output gfi_status_t           status,
	output logic [OPERAND_W-1:0]  inverse,
	output logic                  no_inverse
);

	localparam int DEG_W = $clog2(MAX_DEGREE + 1);

	logic [DEG_W-1:0]     m_sat;
	logic [POLY_W-1:0]    mod_masked;
	logic [OPERAND_W-1:0] op_masked;

	logic [POLY_W-1:0]    u_q, v_q, g1_q, g2_q;
	logic [POLY_W-1:0]    u_nx, v_nx, g1_nx, g2_nx;
	logic [POLY_W-1:0]    a_sel, b_sel, ga_sel, gb_sel;
	logic [PDEG_W-1:0]    du, dv, shamt;
	logic                 swap;

	logic [OPERAND_W-1:0] inverse_q;
	logic                 no_inverse_q;

	always_comb begin
		if (int'(field_degree) < MIN_DEGREE) begin
			m_sat = DEG_W'(MIN_DEGREE);
		end else if (int'(field_degree) > MAX_DEGREE) begin
			m_sat = DEG_W'(MAX_DEGREE);
		end else begin
			m_sat = DEG_W'(field_degree);
		end
	end

	always_comb begin
		for (int i = 0; i < POLY_W; i++) begin
			mod_masked[i] = modulus_poly[i] & (i <= int'(m_sat));
		end
		for (int i = 0; i < OPERAND_W; i++) begin
			op_masked[i] = operand[i] & (i < int'(m_sat));
		end
	end

	assign du   = poly_deg(u_q);
	assign dv   = poly_deg(v_q);
	assign swap = du < dv;

	always_comb begin
		if (swap) begin
			a_sel  = v_q;
			b_sel  = u_q;
			ga_sel = g2_q;
			gb_sel = g1_q;
			shamt  = dv - du;
		end else begin
			a_sel  = u_q;
			b_sel  = v_q;
			ga_sel = g1_q;
			gb_sel = g2_q;
			shamt  = du - dv;
		end
		u_nx  = a_sel ^ (b_sel << shamt);
		v_nx  = b_sel;
		g1_nx = ga_sel ^ (gb_sel << shamt);
		g2_nx = gb_sel;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			u_q  <= POLY_W'(op_masked);
			v_q  <= mod_masked;
			g1_q <= POLY_W'(1);
			g2_q <= '0;
		end else if (cmd.step) begin
			u_q  <= u_nx;
			v_q  <= v_nx;
			g1_q <= g1_nx;
			g2_q <= g2_nx;
		end
	end

	assign status.v_low  = (v_q[POLY_W-1:1] == '0);
	assign status.u_zero = (u_q == '0);
	assign status.u_one  = (u_q == POLY_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inverse_q    <= '0;
			no_inverse_q <= 1'b0;
		end else if (cmd.finish) begin
			if (status.v_low || status.u_zero) begin
				inverse_q    <= '0;
				no_inverse_q <= 1'b1;
			end else begin
				inverse_q    <= g1_q[OPERAND_W-1:0];
				no_inverse_q <= 1'b0;
			end
		end
	end

	assign inverse    = inverse_q;
	assign no_inverse = no_inverse_q;

endmodule

// ===== design/gf2m_inverse.sv =====
// An accepted start loads the operand; the run state then performs the shift-and-XOR steps
// until a final condition, finishes, and the done state strobes the result.
// A new start is taken only in idle; busy stays high until the done cycle ends.
// The step loop shifts and XORs remainder and coefficient in parallel, one step per cycle.
// Reset: arst_n clears the controller and loads modulus 0x11B and degree 8.
// Results are strobed for one cycle on done; the receiver cannot stall them.
// ----------------------------------------------------------------------------
// GF(2^m) multiplicative inverse
// Top level with the configuration registers, the controller and the
// extended Euclid datapath.
// ----------------------------------------------------------------------------
module gf2m_inverse
	import gfi_pkg::*;
#(
	parameter int MAX_DEGREE = DEFAULT_MAX_DEGREE
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [REG_IDX_W-1:0]  wr_index,
	input  logic [MOD_W-1:0]      wr_data,
	input  logic                  start,
	output logic                  busy,
	input  logic [OPERAND_W-1:0]  operand,
	output logic                  done,
	output logic [OPERAND_W-1:0]  inverse,
	output logic                  no_inverse
);

	logic [MOD_W-1:0]    modulus_q;
	logic [DEGREE_W-1:0] degree_q;
	gfi_cmd_t            cmd;
	gfi_status_t         status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= MODULUS_RESET;
			degree_q  <= DEGREE_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_MODULUS: modulus_q <= wr_data;
				REG_DEGREE:  degree_q  <= wr_data[DEGREE_W-1:0];
				default:     modulus_q <= modulus_q;
			endcase
		end
	end

	gfi_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	gfi_datapath #(
		.MAX_DEGREE (MAX_DEGREE)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.operand      (operand),
		.modulus_poly (modulus_q),
		.field_degree (degree_q),
		.status       (status),
		.inverse      (inverse),
		.no_inverse   (no_inverse)
	);

endmodule
